@@ rtl/pfc_pkg.sv @@
// Shared types, format codes and scaling helpers for the pixel format converter.
`timescale 1ns / 1ps

package pfc_pkg;

    typedef logic [2:0] t_fmt;

    localparam t_fmt FMT_L8          = 3'd0;
    localparam t_fmt FMT_RGB565      = 3'd1;
    localparam t_fmt FMT_RGB565_SWAP = 3'd2;
    localparam t_fmt FMT_RGB888      = 3'd3;
    localparam t_fmt FMT_BGR888      = 3'd4;
    localparam t_fmt FMT_XRGB8888    = 3'd5;
    localparam t_fmt FMT_ARGB8888    = 3'd6;
    localparam t_fmt FMT_NONE        = 3'd7;

    // Register indexes on the configuration port
    localparam logic REG_SOURCE_FORMAT = 1'b0;
    localparam logic REG_TARGET_FORMAT = 1'b1;

    localparam t_fmt FMT_RESET = FMT_RGB565;

    // floor(v*255/31) and floor(v*255/63) as multiply by reciprocal
    localparam int unsigned SCALE5_MUL = 255 * 8457;   // 8457 = ceil(2^18 / 31)
    localparam int unsigned SCALE6_MUL = 255 * 16645;  // 16645 = ceil(2^20 / 63)

    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_SWAP,
        KIND_COPY,
        KIND_PACK
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        t_fmt        target_format;
        logic [31:0] pixel;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        row_end;
    } t_work;

    function automatic logic [2:0] fmt_bytes(input t_fmt fmt);
        logic [2:0] n;
        case (fmt)
            FMT_L8:          n = 3'd1;
            FMT_RGB565:      n = 3'd2;
            FMT_RGB565_SWAP: n = 3'd2;
            FMT_RGB888:      n = 3'd3;
            FMT_BGR888:      n = 3'd3;
            FMT_XRGB8888:    n = 3'd4;
            FMT_ARGB8888:    n = 3'd4;
            default:         n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] scale5(input logic [4:0] v);
        logic [26:0] p;
        p = 27'(v) * 27'(SCALE5_MUL);
        return p[25:18];
    endfunction

    function automatic logic [7:0] scale6(input logic [5:0] v);
        logic [28:0] p;
        p = 29'(v) * 29'(SCALE6_MUL);
        return p[27:20];
    endfunction

endpackage

@@ rtl/pfc_front.sv @@
// Front stage: accepts source pixels, classifies the conversion and decodes to 8-bit RGB.
`timescale 1ns / 1ps

module pfc_front import pfc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [31:0] i_source_pixel,
    input  logic        i_row_end_in,
    input  t_fmt        i_source_format,
    input  t_fmt        i_target_format,
    output logic        o_valid,
    output t_work       o_work,
    input  logic        i_ready
);

    logic        r_valid;
    logic        n_valid;
    t_work       r_work;
    t_work       n_work;
    logic        accept;
    logic [15:0] w565;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;

    assign o_full  = r_valid && !i_ready;
    assign accept  = i_push && !o_full;
    assign o_valid = r_valid;
    assign o_work  = r_work;

    assign b0 = i_source_pixel[7:0];
    assign b1 = i_source_pixel[15:8];
    assign b2 = i_source_pixel[23:16];

    always_comb begin
        n_work               = '0;
        n_work.target_format = i_target_format;
        n_work.pixel         = i_source_pixel;
        n_work.row_end       = i_row_end_in;
        w565                 = (i_source_format == FMT_RGB565_SWAP) ? {b0, b1} : {b1, b0};

        if (i_target_format == FMT_NONE) begin
            n_work.kind = KIND_ZERO;
        end else if (i_source_format == i_target_format) begin
            n_work.kind = (i_target_format == FMT_RGB565) ? KIND_SWAP : KIND_COPY;
        end else begin
            n_work.kind = KIND_PACK;
        end

        // decode; an undefined source format stays black
        case (i_source_format)
            FMT_L8: begin
                n_work.red   = b0;
                n_work.green = b0;
                n_work.blue  = b0;
            end
            FMT_RGB565, FMT_RGB565_SWAP: begin
                n_work.red   = scale5(w565[15:11]);
                n_work.green = scale6(w565[10:5]);
                n_work.blue  = scale5(w565[4:0]);
            end
            FMT_RGB888, FMT_XRGB8888, FMT_ARGB8888: begin
                n_work.blue  = b0;
                n_work.green = b1;
                n_work.red   = b2;
            end
            FMT_BGR888: begin
                n_work.red   = b0;
                n_work.green = b1;
                n_work.blue  = b2;
            end
            default: begin
                n_work.red   = 8'd0;
                n_work.green = 8'd0;
                n_work.blue  = 8'd0;
            end
        endcase
    end

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_work <= n_work;
        end
    end

endmodule

@@ rtl/pfc_queue.sv @@
// Short queue of classified pixels between the front and back stages.
`timescale 1ns / 1ps

module pfc_queue import pfc_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    output logic  o_full,
    input  t_work i_work,
    output logic  o_valid,
    output t_work o_work,
    input  logic  i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_work              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_work  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from an empty queue");

endmodule

@@ rtl/pfc_back.sv @@
// Back stage: packs the classified pixel into the target format and holds the result.
`timescale 1ns / 1ps

module pfc_back import pfc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_work       i_work,
    output logic        o_ready,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [31:0] o_target_pixel,
    output logic [2:0]  o_target_bytes,
    output logic        o_row_end_out
);

    logic        r_valid;
    logic        n_valid;
    logic [31:0] r_target_pixel;
    logic [2:0]  r_target_bytes;
    logic        r_row_end_out;
    logic [31:0] n_target_pixel;
    logic [31:0] packed_pixel;
    logic [31:0] copy_mask;
    logic [15:0] lum;
    logic [15:0] w565;
    logic [2:0]  nbytes;
    logic        load;

    assign o_ready = !r_valid || i_pop;
    assign load    = i_valid && o_ready;
    assign o_empty = !r_valid;
    assign o_target_pixel = r_target_pixel;
    assign o_target_bytes = r_target_bytes;
    assign o_row_end_out  = r_row_end_out;

    assign nbytes = fmt_bytes(i_work.target_format);
    assign lum    = 16'(i_work.red) * 16'd77 + 16'(i_work.green) * 16'd151
                  + 16'(i_work.blue) * 16'd28;
    assign w565   = {i_work.red[7:3], i_work.green[7:2], i_work.blue[7:3]};

    always_comb begin
        case (i_work.target_format)
            FMT_L8:                      packed_pixel = {24'd0, lum[15:8]};
            FMT_RGB565, FMT_RGB565_SWAP: packed_pixel = {16'd0, w565[7:0], w565[15:8]};
            FMT_RGB888:   packed_pixel = {8'd0, i_work.red, i_work.green, i_work.blue};
            FMT_BGR888:   packed_pixel = {8'd0, i_work.blue, i_work.green, i_work.red};
            FMT_XRGB8888, FMT_ARGB8888:
                          packed_pixel = {8'hff, i_work.red, i_work.green, i_work.blue};
            default:      packed_pixel = 32'd0;
        endcase
    end

    always_comb begin
        case (nbytes)
            3'd1:    copy_mask = 32'h0000_00ff;
            3'd2:    copy_mask = 32'h0000_ffff;
            3'd3:    copy_mask = 32'h00ff_ffff;
            default: copy_mask = 32'hffff_ffff;
        endcase
    end

    always_comb begin
        case (i_work.kind)
            KIND_ZERO: n_target_pixel = 32'd0;
            KIND_SWAP: n_target_pixel = {16'd0, i_work.pixel[7:0], i_work.pixel[15:8]};
            KIND_COPY: n_target_pixel = i_work.pixel & copy_mask;
            KIND_PACK: n_target_pixel = packed_pixel;
            default:   n_target_pixel = 32'd0;
        endcase
    end

    always_comb begin
        if (load) begin
            n_valid = 1'b1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_target_pixel <= n_target_pixel;
            r_target_bytes <= nbytes;
            r_row_end_out  <= i_work.row_end;
        end
    end

endmodule

@@ rtl/pixel_format_converter.sv @@
// Top level of the pixel format converter: configuration registers and stage wiring.
`timescale 1ns / 1ps

// Converts one source pixel per transfer into one destination pixel.
// Input channel: drive i_source_pixel and i_row_end_in with push; a transfer
// happens at a clock edge with push high and full low.
// Result channel: while empty is low the oldest result sits on o_target_pixel,
// o_target_bytes and o_row_end_out; pop at an edge with empty low takes it.
// Configuration: APB registers source_format at 0x0 and target_format at 0x4,
// both reset to RGB565. Change them only while no pixel is in flight.
// The path runs through the front register (classify and decode), the queue
// and the back output register (pack). Throughput is one pixel per clock
// while the receiver pops; the front and the back each hold a pixel and the
// queue holds QUEUE_DEPTH, so the input keeps flowing while a result
// waits. When the receiver stalls, pixels pile up in those stages and full
// rises once all are occupied. Synchronous reset empties every stage.
module pixel_format_converter import pfc_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_source_pixel,
    input  logic        i_row_end_in,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_target_pixel,
    output logic [2:0]  o_target_bytes,
    output logic        o_row_end_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_fmt  r_source_format;
    t_fmt  r_target_format;
    logic  cfg_write;
    logic  front_valid;
    t_work front_work;
    logic  q_full;
    logic  q_valid;
    t_work q_work;
    logic  back_ready;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_TARGET_FORMAT) ? {29'd0, r_target_format}
                                                       : {29'd0, r_source_format};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_format <= FMT_RESET;
            r_target_format <= FMT_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_SOURCE_FORMAT: r_source_format <= pwdata[2:0];
                REG_TARGET_FORMAT: r_target_format <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    pfc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_source_pixel  (i_source_pixel),
        .i_row_end_in    (i_row_end_in),
        .i_source_format (r_source_format),
        .i_target_format (r_target_format),
        .o_valid         (front_valid),
        .o_work          (front_work),
        .i_ready         (!q_full)
    );

    pfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid && !q_full),
        .o_full  (q_full),
        .i_work  (front_work),
        .o_valid (q_valid),
        .o_work  (q_work),
        .i_pop   (q_valid && back_ready)
    );

    pfc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .i_work         (q_work),
        .o_ready        (back_ready),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_target_pixel (o_target_pixel),
        .o_target_bytes (o_target_bytes),
        .o_row_end_out  (o_row_end_out)
    );

    a_bytes_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_target_bytes != 3'd0 && o_target_bytes <= 3'd4))
        else $error("target byte count out of range");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_target_bytes == 3'd1) |-> (o_target_pixel[31:8] == 24'd0))
        else $error("unused destination bytes not zero");

endmodule

@@ bench/tb_pixel_format_converter.sv @@
// Self-checking testbench for the pixel format converter: directed and random pixels.
`timescale 1ns / 1ps

module tb_pixel_format_converter;
    import pfc_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    typedef struct {
        logic [31:0] pixel;
        logic [2:0]  nbytes;
        logic        row_end;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [31:0] i_source_pixel = '0;
    logic        i_row_end_in = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] o_target_pixel;
    logic [2:0]  o_target_bytes;
    logic        o_row_end_out;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    t_result     pending_pixels[$];
    t_result     oldest;
    t_fmt        cur_src = FMT_RESET;
    t_fmt        cur_dst = FMT_RESET;
    int          mismatches = 0;
    int          cycle_count = 0;
    int          hold_left = 0;
    int          long_hold_req = 0;
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;

    pixel_format_converter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_source_pixel (i_source_pixel),
        .i_row_end_in   (i_row_end_in),
        .empty          (empty),
        .pop            (pop),
        .o_target_pixel (o_target_pixel),
        .o_target_bytes (o_target_bytes),
        .o_row_end_out  (o_row_end_out),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL pixel_format_converter");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got 0x%08h, want 0x%08h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic logic [2:0] format_bytes(input t_fmt fmt);
        case (fmt)
            FMT_L8:                      return 3'd1;
            FMT_RGB565, FMT_RGB565_SWAP: return 3'd2;
            FMT_RGB888, FMT_BGR888:      return 3'd3;
            FMT_XRGB8888, FMT_ARGB8888:  return 3'd4;
            default:                     return 3'd1;
        endcase
    endfunction

    function automatic t_result convert_pixel(input t_fmt src, input t_fmt dst,
                                              input logic [31:0] px, input logic row_end);
        t_result     res;
        logic [15:0] word;
        logic [15:0] w565;
        logic [7:0]  red;
        logic [7:0]  grn;
        logic [7:0]  blu;
        res.nbytes  = format_bytes(dst);
        res.row_end = row_end;
        red  = 8'h0;
        grn  = 8'h0;
        blu  = 8'h0;
        word = 16'h0;
        if (dst == FMT_NONE) begin
            res.pixel = 32'h0;
        end else if (src == dst && dst == FMT_RGB565) begin
            res.pixel = {16'h0, px[7:0], px[15:8]};
        end else if (src == dst) begin
            res.pixel = px & (32'hffff_ffff >> (8 * (4 - res.nbytes)));
        end else begin
            case (src)
                FMT_L8: begin
                    red = px[7:0];
                    grn = px[7:0];
                    blu = px[7:0];
                end
                FMT_RGB565:      word = px[15:0];
                FMT_RGB565_SWAP: word = {px[7:0], px[15:8]};
                FMT_RGB888, FMT_XRGB8888, FMT_ARGB8888: begin
                    blu = px[7:0];
                    grn = px[15:8];
                    red = px[23:16];
                end
                FMT_BGR888: begin
                    red = px[7:0];
                    grn = px[15:8];
                    blu = px[23:16];
                end
                default: ;
            endcase
            // widen 5- and 6-bit channels to full 8-bit range
            if (src == FMT_RGB565 || src == FMT_RGB565_SWAP) begin
                red = 8'((int'(word[15:11]) * 255) / 31);
                grn = 8'((int'(word[10:5]) * 255) / 63);
                blu = 8'((int'(word[4:0]) * 255) / 31);
            end
            case (dst)
                FMT_L8: res.pixel = 32'((77 * red + 151 * grn + 28 * blu) >> 8);
                FMT_RGB565, FMT_RGB565_SWAP: begin
                    w565      = {red[7:3], grn[7:2], blu[7:3]};
                    res.pixel = {16'h0, w565[7:0], w565[15:8]};
                end
                FMT_RGB888:                 res.pixel = {8'h00, red, grn, blu};
                FMT_BGR888:                 res.pixel = {8'h00, blu, grn, red};
                FMT_XRGB8888, FMT_ARGB8888: res.pixel = {8'hff, red, grn, blu};
                default:                    res.pixel = 32'h0;
            endcase
        end
        return res;
    endfunction

    function automatic logic [31:0] random_pixel();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // Receiver: pop with random stall bursts, or one long hold on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (long_hold_req != 0) begin
            pop           <= 1'b0;
            hold_left     <= long_hold_req - 1;
            long_hold_req = 0;
        end else if (hold_left != 0) begin
            pop       <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (rx_idle && $urandom_range(0, 5) == 0) begin
            pop       <= 1'b0;
            hold_left <= $urandom_range(0, 15);
        end else begin
            pop <= 1'b1;
        end
    end

    // Compare every result transfer with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("unexpected result", o_target_pixel, 32'h0);
            end else begin
                oldest = pending_pixels.pop_front();
                if (o_target_pixel !== oldest.pixel)
                    report_mismatch("target_pixel", o_target_pixel, oldest.pixel);
                if (o_target_bytes !== oldest.nbytes)
                    report_mismatch("target_bytes", 32'(o_target_bytes), 32'(oldest.nbytes));
                if (o_row_end_out !== oldest.row_end)
                    report_mismatch("row_end_out", 32'(o_row_end_out), 32'(oldest.row_end));
            end
        end
    end

    task automatic send_pixel(input logic [31:0] px, input logic row_end);
        t_result want;
        want = convert_pixel(cur_src, cur_dst, px, row_end);
        if (tx_idle && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        push           <= 1'b1;
        i_source_pixel <= px;
        i_row_end_in   <= row_end;
        do @(posedge i_clk); while (full);
        pending_pixels.push_back(want);
    endtask

    // Lower push in the step of the last transfer, then wait for all results.
    task automatic drain_pixels();
        push <= 1'b0;
        do @(posedge i_clk); while (pending_pixels.size() != 0);
    endtask

    task automatic apb_access(input logic wr, input logic idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_register(input logic idx, input t_fmt want);
        logic [31:0] rdata;
        apb_access(1'b0, idx, 32'h0, rdata);
        if (rdata !== 32'(want))
            report_mismatch(idx == REG_SOURCE_FORMAT ? "source_format read" :
                            "target_format read", rdata, 32'(want));
    endtask

    task automatic set_formats(input t_fmt src, input t_fmt dst);
        logic [31:0] unused;
        drain_pixels();
        apb_access(1'b1, REG_SOURCE_FORMAT, 32'(src), unused);
        cur_src = src;
        apb_access(1'b1, REG_TARGET_FORMAT, 32'(dst), unused);
        cur_dst = dst;
        check_register(REG_SOURCE_FORMAT, src);
        check_register(REG_TARGET_FORMAT, dst);
    endtask

    task automatic test_reset_defaults();
        drain_pixels();
        check_register(REG_SOURCE_FORMAT, FMT_RESET);
        check_register(REG_TARGET_FORMAT, FMT_RESET);
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'hffff_ffff, 1'b1);
        send_pixel(32'h1234_abcd, 1'b0);
    endtask

    task automatic test_directed_formats();
        set_formats(FMT_L8, FMT_RGB565);
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'hffff_ff80, 1'b1);
        set_formats(FMT_RGB565, FMT_RGB888);
        send_pixel(32'h0000_ffff, 1'b0);
        send_pixel(32'hffff_0000, 1'b0);
        send_pixel(32'h0000_f800, 1'b0);
        send_pixel(32'habcd_07e0, 1'b1);
        set_formats(FMT_RGB565_SWAP, FMT_ARGB8888);
        send_pixel(32'h0000_ffff, 1'b0);
        send_pixel(32'h0000_1ff8, 1'b1);
        set_formats(FMT_BGR888, FMT_L8);
        send_pixel(32'h00ff_ffff, 1'b0);
        send_pixel(32'hff00_00ff, 1'b1);
        set_formats(FMT_XRGB8888, FMT_BGR888);
        send_pixel(32'h1234_5678, 1'b0);
        set_formats(FMT_ARGB8888, FMT_RGB565_SWAP);
        send_pixel(32'h00ff_ffff, 1'b1);
        set_formats(FMT_RGB888, FMT_XRGB8888);
        send_pixel(32'hff80_4020, 1'b0);
        // equal formats copy the pixel, masked to its size
        set_formats(FMT_RGB888, FMT_RGB888);
        send_pixel(32'hffff_ffff, 1'b0);
        set_formats(FMT_ARGB8888, FMT_ARGB8888);
        send_pixel(32'hffff_ffff, 1'b1);
        set_formats(FMT_RGB565_SWAP, FMT_RGB565_SWAP);
        send_pixel(32'hdead_beef, 1'b0);
        set_formats(FMT_L8, FMT_L8);
        send_pixel(32'hffff_ffff, 1'b1);
        // undefined source decodes black, undefined target yields zero
        set_formats(FMT_NONE, FMT_RGB888);
        send_pixel(32'hffff_ffff, 1'b0);
        set_formats(FMT_RGB888, FMT_NONE);
        send_pixel(32'hffff_ffff, 1'b1);
        set_formats(FMT_NONE, FMT_NONE);
        send_pixel(32'hffff_ffff, 1'b0);
    endtask

    task automatic test_random_formats(input int count);
        int   sent;
        int   burst;
        t_fmt src;
        t_fmt dst;
        sent = 0;
        while (sent < count) begin
            src = t_fmt'($urandom_range(0, 7));
            dst = ($urandom_range(0, 3) == 0) ? src : t_fmt'($urandom_range(0, 7));
            set_formats(src, dst);
            burst = $urandom_range(10, 60);
            repeat (burst) send_pixel(random_pixel(), $urandom_range(0, 7) == 0);
            sent += burst;
        end
    endtask

    task automatic test_backpressure();
        set_formats(FMT_RGB565_SWAP, FMT_BGR888);
        @(negedge i_clk);
        long_hold_req = 300;
        @(posedge i_clk);
        repeat (40) send_pixel(random_pixel(), $urandom_range(0, 7) == 0);
    endtask

    task automatic test_streaming();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        set_formats(FMT_XRGB8888, FMT_L8);
        repeat (100) send_pixel(random_pixel(), $urandom_range(0, 7) == 0);
        set_formats(FMT_L8, FMT_RGB565);
        repeat (100) send_pixel(random_pixel(), $urandom_range(0, 7) == 0);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_directed_formats();
        test_random_formats(1300);
        test_backpressure();
        test_streaming();
        drain_pixels();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS pixel_format_converter");
        end else begin
            $display("FAIL pixel_format_converter");
        end
        $finish;
    end

endmodule
